/* hdl/mksq_pkg.sv */
`timescale 1ns / 1ps

package mksq_pkg;

  localparam int SlotCountDef = 32;
  localparam int KeyW         = 16;
  localparam int SlotNumW     = 5;

  typedef enum logic [1:0] {
    FuncAdd     = 2'd0,
    FuncGet     = 2'd1,
    FuncFlush   = 2'd2,
    FuncRelease = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StEmpty   = 2'd2,
    StBadSlot = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StateIdle,
    StateAdd,
    StateGet,
    StateLast
  } state_e;

  typedef struct packed {
    func_e                func;
    logic [KeyW-1:0]      wave_height_bits;
    logic [SlotNumW-1:0]  slot_index;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [SlotNumW-1:0]  result_slot;
    logic                 found;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } best_ctl_t;

  function automatic logic key_qualifies(logic [KeyW-1:0] k);
    logic [KeyW-2:0] mag;
    mag = k[KeyW-2:0];
    if (mag > 15'h7C00) begin
      return 1'b0;
    end
    if (k[KeyW-1] && (mag != '0)) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

endpackage

/* hdl/mksq_best_tracker.sv */
`timescale 1ns / 1ps

module mksq_best_tracker import mksq_pkg::*; #(
  parameter int IdxW = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  best_ctl_t         ctl_i,
  input  logic [IdxW-1:0]   idx_i,
  input  logic [KeyW-1:0]   key_i,
  output logic              have_o,
  output logic [IdxW-1:0]   idx_o
);

  logic            have_q, have_d;
  logic [KeyW-2:0] mag_q, mag_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_comb begin
    have_d = have_q;
    mag_d  = mag_q;
    idx_d  = idx_q;
    if (ctl_i.clear) begin
      have_d = 1'b0;
      mag_d  = '0;
      idx_d  = '0;
    end else if (ctl_i.sample && key_qualifies(key_i) && (key_i[KeyW-2:0] >= mag_q)) begin
      have_d = 1'b1;
      mag_d  = key_i[KeyW-2:0];
      idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      mag_q  <= '0;
      idx_q  <= '0;
    end else begin
      have_q <= have_d;
      mag_q  <= mag_d;
      idx_q  <= idx_d;
    end
  end

  assign have_o = have_d;
  assign idx_o  = idx_d;

endmodule

/* hdl/max_key_slot_queue.sv */
`timescale 1ns / 1ps
// Flush, release, add to a full table and get on an empty table finish from idle without a scan.
// Add: scans the valid bits for the first free slot, one slot of the valid scan per cycle.
// Get: reads every slot, one key memory read per cycle plus one compare stage.
// One command at a time; busy stays high while a scan runs.
// Reset clears all valid bits and the count; key memory content is not cleared.
// The result beat shows for one cycle on done_o; the receiver cannot stall.

module max_key_slot_queue import mksq_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CntW = $clog2(SLOT_COUNT + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(SLOT_COUNT - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(SLOT_COUNT);

  state_e                state_q, state_d;
  logic [IdxW-1:0]       scan_q, scan_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [KeyW-1:0]       key_q, key_d;
  logic                  done_q, done_d;
  rsp_t                  rsp_q, rsp_d;

  logic                  wr_en, rd_en;
  logic                  rd_pend_q, rd_sv_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [KeyW-1:0]       rd_data_q;
  logic [IdxW-1:0]       rel_idx;
  logic                  rel_ok;
  best_ctl_t             best_ctl;
  logic                  best_have;
  logic [IdxW-1:0]       best_idx;

  logic [KeyW-1:0]       key_mem [SLOT_COUNT];

  assign rel_idx = IdxW'(cmd_i.slot_index);
  assign rel_ok  = (32'(cmd_i.slot_index) < SLOT_COUNT) && valid_q[rel_idx];

  always_comb begin
    state_d         = state_q;
    scan_d          = scan_q;
    valid_d         = valid_q;
    count_d         = count_q;
    key_d           = key_q;
    done_d          = 1'b0;
    rsp_d           = '0;
    rsp_d.status    = StOk;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    best_ctl.clear  = 1'b0;
    best_ctl.sample = rd_pend_q && rd_sv_q;
    unique case (state_q)
      StateIdle: begin
        if (start) begin
          unique case (cmd_i.func)
            FuncAdd: begin
              if (count_q >= FullCnt) begin
                done_d       = 1'b1;
                rsp_d.status = StFull;
              end else begin
                key_d   = cmd_i.wave_height_bits;
                scan_d  = '0;
                state_d = StateAdd;
              end
            end
            FuncGet: begin
              if (count_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = StEmpty;
              end else begin
                scan_d         = '0;
                best_ctl.clear = 1'b1;
                state_d        = StateGet;
              end
            end
            FuncFlush: begin
              valid_d = '0;
              count_d = '0;
              done_d  = 1'b1;
            end
            FuncRelease: begin
              done_d = 1'b1;
              if (rel_ok) begin
                valid_d[rel_idx] = 1'b0;
                count_d          = count_q - CntW'(1);
              end else begin
                rsp_d.status = StBadSlot;
              end
            end
            default: ;
          endcase
        end
      end
      StateAdd: begin
        if (!valid_q[scan_q]) begin
          wr_en             = 1'b1;
          valid_d[scan_q]   = 1'b1;
          count_d           = count_q + CntW'(1);
          done_d            = 1'b1;
          rsp_d.result_slot = SlotNumW'(scan_q);
          rsp_d.found       = 1'b1;
          state_d           = StateIdle;
        end else if (scan_q == LastIdx) begin
          done_d       = 1'b1;
          rsp_d.status = StFull;
          state_d      = StateIdle;
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end
      StateGet: begin
        rd_en = 1'b1;
        if (scan_q == LastIdx) begin
          state_d = StateLast;
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end
      StateLast: begin
        done_d            = 1'b1;
        rsp_d.found       = best_have;
        rsp_d.result_slot = best_have ? SlotNumW'(best_idx) : '0;
        state_d           = StateIdle;
      end
      default: state_d = StateIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateIdle;
      scan_q    <= '0;
      valid_q   <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      done_q    <= done_d;
      rd_pend_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    rsp_q    <= rsp_d;
    rd_idx_q <= scan_q;
    rd_sv_q  <= valid_q[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[scan_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= key_mem[scan_q];
    end
  end

  mksq_best_tracker #(
    .IdxW (IdxW)
  ) u_best (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (best_ctl),
    .idx_i  (rd_idx_q),
    .key_i  (rd_data_q),
    .have_o (best_have),
    .idx_o  (best_idx)
  );

  assign busy   = (state_q != StateIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("count differs from number of valid slots");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= SLOT_COUNT)
    else $error("count exceeds slot count");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.found |-> rsp_o.status == StOk)
    else $error("found set with error status");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(start && !busy) || $past(busy))
    else $error("result beat without a command");

  a_read_in_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StateLast |-> rd_pend_q)
    else $error("last compare without pending read");

endmodule

/* sim/slot_table_check.sv */
`timescale 1ns / 1ps

module slot_table_check import mksq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  cmd_t cmd_i,
  input  logic done_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic            slot_used [SlotCountDef];
  logic [KeyW-1:0] slot_prio [SlotCountDef];
  int              occupancy;
  rsp_t            expected_rsp_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic prio_ranked(logic [KeyW-1:0] k);
    return !(k[KeyW-2:0] > 15'h7C00) && !(k[KeyW-1] && (k[KeyW-2:0] != '0));
  endfunction

  function automatic rsp_t apply_cmd(cmd_t c);
    rsp_t            r;
    logic [KeyW-2:0] top_mag;
    int              pick;
    logic            have;
    r = '0;
    r.status = StOk;
    top_mag = '0;
    pick = -1;
    have = 1'b0;
    case (c.func)
      FuncAdd: begin
        if (occupancy < SlotCountDef) begin
          for (int i = 0; i < SlotCountDef; i++) begin
            if (pick < 0 && !slot_used[i]) begin
              pick = i;
            end
          end
        end
        if (pick < 0) begin
          r.status = StFull;
        end else begin
          slot_used[pick] = 1'b1;
          slot_prio[pick] = c.wave_height_bits;
          occupancy++;
          r.result_slot = SlotNumW'(pick);
          r.found = 1'b1;
        end
      end
      FuncGet: begin
        if (occupancy == 0) begin
          r.status = StEmpty;
        end else begin
          for (int i = 0; i < SlotCountDef; i++) begin
            if (slot_used[i] && prio_ranked(slot_prio[i]) &&
                slot_prio[i][KeyW-2:0] >= top_mag) begin
              top_mag = slot_prio[i][KeyW-2:0];
              pick = i;
              have = 1'b1;
            end
          end
          if (have) begin
            r.result_slot = SlotNumW'(pick);
            r.found = 1'b1;
          end
        end
      end
      FuncFlush: begin
        for (int i = 0; i < SlotCountDef; i++) begin
          slot_used[i] = 1'b0;
        end
        occupancy = 0;
      end
      default: begin
        if (int'(c.slot_index) < SlotCountDef && slot_used[c.slot_index]) begin
          slot_used[c.slot_index] = 1'b0;
          occupancy--;
        end else begin
          r.status = StBadSlot;
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SlotCountDef; i++) begin
        slot_used[i] = 1'b0;
        slot_prio[i] = '0;
      end
      occupancy = 0;
      expected_rsp_q.delete();
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status !== want.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      rsp_i.status, want.status));
          end
          if (rsp_i.result_slot !== want.result_slot) begin
            report_mismatch($sformatf("result_slot got %0d expected %0d",
                                      rsp_i.result_slot, want.result_slot));
          end
          if (rsp_i.found !== want.found) begin
            report_mismatch($sformatf("found got %0d expected %0d",
                                      rsp_i.found, want.found));
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_rsp_q.push_back(apply_cmd(cmd_i));
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

/* sim/max_key_slot_queue_test.sv */
`timescale 1ns / 1ps

module max_key_slot_queue_test;
  import mksq_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int TailCycles = SlotCountDef + 8;
  localparam int RandomBeats = 1800;

  typedef enum int {
    BurstFill,
    BurstDrain,
    BurstMixed
  } burst_e;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  rsp_t rsp;
  int   fail_count;
  int   outstanding;
  int   cycle_count;
  int   sent;
  logic quiet;

  logic [KeyW-1:0] edge_keys [8] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00,
                                     16'h7C01, 16'hFFFF, 16'h7BFF, 16'h0001};
  logic [KeyW-1:0] tie_keys [4] = '{16'h3C00, 16'h4000, 16'h0000, 16'h8000};

  max_key_slot_queue #(
    .SLOT_COUNT(SlotCountDef)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd),
    .done_o(done),
    .rsp_o (rsp)
  );

  slot_table_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .cmd_i       (cmd),
    .done_i      (done),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(func_e f, logic [KeyW-1:0] k, logic [SlotNumW-1:0] s);
    cmd_t c;
    c.func = f;
    c.wave_height_bits = k;
    c.slot_index = s;
    return c;
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return KeyW'($urandom);
    end else if (roll < 6) begin
      return edge_keys[$urandom_range(0, 7)];
    end else if (roll < 8) begin
      return tie_keys[$urandom_range(0, 3)];
    end
    return KeyW'($urandom_range(0, 16'h7C00));
  endfunction

  function automatic func_e pick_func(burst_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      BurstFill: begin
        if (roll < 85) return FuncAdd;
        if (roll < 95) return FuncGet;
        return FuncRelease;
      end
      BurstDrain: begin
        if (roll < 60) return FuncRelease;
        if (roll < 95) return FuncGet;
        return FuncAdd;
      end
      default: begin
        if (roll < 35) return FuncAdd;
        if (roll < 70) return FuncGet;
        if (roll < 96) return FuncRelease;
        return FuncFlush;
      end
    endcase
  endfunction

  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain_wait();
    start <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  initial begin
    burst_e mode;
    int     burst_len;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd = '0;
    cycle_count = 0;
    sent = 0;
    quiet = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_cmd(make_cmd(FuncGet, 16'h1234, 5'd0));
    send_cmd(make_cmd(FuncRelease, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncRelease, 16'hFFFF, 5'd31));
    send_cmd(make_cmd(FuncFlush, 16'h0000, 5'd31));
    send_cmd(make_cmd(FuncAdd, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'h8000, 5'd31));
    send_cmd(make_cmd(FuncGet, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'h7C00, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'h7BFF, 5'd0));
    send_cmd(make_cmd(FuncGet, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'h7C01, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'hFFFF, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'hFC00, 5'd0));
    send_cmd(make_cmd(FuncGet, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncRelease, 16'h0000, 5'd2));
    send_cmd(make_cmd(FuncGet, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'h7BFF, 5'd0));
    send_cmd(make_cmd(FuncGet, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncRelease, 16'h0000, 5'd3));
    send_cmd(make_cmd(FuncRelease, 16'h0000, 5'd3));
    send_cmd(make_cmd(FuncFlush, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'hBC00, 5'd0));
    send_cmd(make_cmd(FuncAdd, 16'hFFFF, 5'd0));
    send_cmd(make_cmd(FuncGet, 16'h0000, 5'd0));
    send_cmd(make_cmd(FuncFlush, 16'h0000, 5'd0));

    while (sent < RandomBeats) begin
      drain_wait();
      mode = burst_e'($urandom_range(0, 2));
      burst_len = $urandom_range(20, 60);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        send_cmd(make_cmd(pick_func(mode), pick_key(), SlotNumW'($urandom_range(0, 31))));
        sent++;
      end
    end

    drain_wait();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/mksq_pkg.sv
hdl/mksq_best_tracker.sv
hdl/max_key_slot_queue.sv
sim/slot_table_check.sv
sim/max_key_slot_queue_test.sv
